// ===== rtl/button_debounce_press_classifier_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the button debounce press classifier
// ---------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_TOP_DEFINES_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_TOP_DEFINES_SVH

// checked outside reset only
`define BDPC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define BDPC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bdpc_pkg.sv =====
// ---------------------------------------------------------------------------
// bdpc_pkg
// Types and constants shared by the button debounce press classifier.
// ---------------------------------------------------------------------------
package bdpc_pkg;

	localparam int TimeBits = 32;
	localparam int StampBits = 32;
	localparam int LimitBits = 16;
	localparam int InDataBits = 40;
	localparam int OutDataBits = 8;

	typedef logic [TimeBits-1:0] time_t;
	typedef logic [LimitBits-1:0] limit_t;

	// register indexes
	localparam logic RegDebounce = 1'b0;
	localparam logic RegLongPress = 1'b1;

	localparam limit_t DebounceReset = 16'd50;
	localparam limit_t LongPressReset = 16'd1000;

	typedef enum logic [3:0] {
		ST_IDLE        = 4'b0001,
		ST_DEB_PRESS   = 4'b0010,
		ST_PRESSED     = 4'b0100,
		ST_DEB_RELEASE = 4'b1000
	} press_state_t;

	typedef struct packed {
		limit_t debounce_time;
		limit_t long_press_time;
	} cfg_t;

	typedef struct packed {
		logic held;
		logic long_press;
		logic short_press;
	} result_t;

	// time stamp port width to internal time width (zero-extend or truncate)
	function automatic time_t to_time(input logic [StampBits-1:0] stamp);
		logic [TimeBits+StampBits-1:0] wide;
		begin
			wide = {{TimeBits{1'b0}}, stamp};
			return wide[TimeBits-1:0];
		end
	endfunction

	function automatic logic reached(input time_t elapsed, input limit_t limit);
		logic [TimeBits+LimitBits-1:0] e;
		logic [TimeBits+LimitBits-1:0] l;
		begin
			e = {{LimitBits{1'b0}}, elapsed};
			l = {{TimeBits{1'b0}}, limit};
			return e >= l;
		end
	endfunction

endpackage

// ===== rtl/bdpc_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// bdpc_cfg_regs
// Debounce and long-press limit registers behind the write port.
// ---------------------------------------------------------------------------
module bdpc_cfg_regs
	import bdpc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  limit_t       cfg_data,
	output cfg_t         cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time <= DebounceReset;
			cfg_q.long_press_time <= LongPressReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegDebounce:  cfg_q.debounce_time <= cfg_data;
				RegLongPress: cfg_q.long_press_time <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/bdpc_fsm.sv =====
// ---------------------------------------------------------------------------
// bdpc_fsm
// Press qualification state machine with state entry time stamp.
// ---------------------------------------------------------------------------
module bdpc_fsm
	import bdpc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    adv,
	input  logic    level,
	input  time_t   now,
	output result_t res
);

	press_state_t state_q, state_d;
	time_t entry_q, entry_d;
	time_t elapsed;
	logic deb_done;
	logic long_done;

	assign elapsed = now - entry_q;
	assign deb_done = reached(elapsed, cfg.debounce_time);
	assign long_done = reached(elapsed, cfg.long_press_time);

	always_comb begin
		state_d = state_q;
		entry_d = entry_q;
		res = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (level) begin
					state_d = ST_DEB_PRESS;
					entry_d = now;
				end
			end
			ST_DEB_PRESS: begin
				if (!level) begin
					state_d = ST_IDLE;
				end else if (deb_done) begin
					state_d = ST_PRESSED;
					entry_d = now;
				end
			end
			ST_PRESSED: begin
				if (!level) begin
					res.long_press = long_done;
					res.short_press = !long_done;
					state_d = ST_DEB_RELEASE;
					entry_d = now;
				end
			end
			ST_DEB_RELEASE: begin
				// level ignored, time only
				if (deb_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		res.held = (state_d == ST_PRESSED);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			entry_q <= '0;
		end else if (adv) begin
			state_q <= state_d;
			entry_q <= entry_d;
		end
	end

endmodule

// ===== rtl/button_debounce_press_classifier_top.sv =====
// ---------------------------------------------------------------------------
// button_debounce_press_classifier_top
// Debounces button polls and flags short and long presses on release.
// ---------------------------------------------------------------------------
//  channel | direction | payload
//  s_axis  | in        | tdata: button_level, time_now
//  m_axis  | out       | tdata: short_press, long_press, held
//  cfg     | in        | register write: debounce_time, long_press_time
//
// One word per cycle sustained while m_axis is ready; a word passes the input
// register, then the state update into the result register.
// The state machine and entry stamp advance when a word moves from the
// input register into the result register.
// arst_n returns the machine to idle with entry time zero and limits 50/1000.
// A stall on m_axis backs up through both registers to s_axis_tready.
// ---------------------------------------------------------------------------
`include "button_debounce_press_classifier_top_defines.svh"

module button_debounce_press_classifier_top
	import bdpc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [InDataBits-1:0]  s_axis_tdata,  // [0] button_level, [32:1] time_now
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OutDataBits-1:0] m_axis_tdata,  // [0] short_press, [1] long_press, [2] held
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  limit_t                 cfg_data
);

	cfg_t cfg;
	result_t res;

	logic in_vld_s1;
	logic level_s1;
	time_t time_s1;
	logic out_vld_q;
	result_t out_res_q;
	logic out_load;
	logic adv;

	assign out_load = !out_vld_q || m_axis_tready;
	assign adv = in_vld_s1 && out_load;
	assign s_axis_tready = !in_vld_s1 || out_load;

	bdpc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bdpc_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.adv    (adv),
		.level  (level_s1),
		.now    (time_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				in_vld_s1 <= s_axis_tvalid;
			end
			if (out_load) begin
				out_vld_q <= in_vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			level_s1 <= s_axis_tdata[0];
			time_s1 <= to_time(s_axis_tdata[StampBits:1]);
		end
		if (adv) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = {{(OutDataBits - $bits(result_t)){1'b0}}, out_res_q};

	`BDPC_ASSERT_ALWAYS(a_one_pulse, !(out_vld_q && out_res_q.short_press && out_res_q.long_press), "short and long press on one word")
	`BDPC_ASSERT(a_pulse_not_held, (adv && (res.short_press || res.long_press)) |-> !res.held, "release pulse while held")
	`BDPC_ASSERT(a_stall_backs_up, (in_vld_s1 && out_vld_q && !m_axis_tready) |-> !s_axis_tready, "input taken while both stages full")

endmodule

// ===== verif/tb_button_debounce_press_classifier_top.sv =====
// ---------------------------------------------------------------------------
// tb_button_debounce_press_classifier_top
// Streams button polls through the debounce classifier and checks every
// result word against a cycle-free model of the four-state press machine.
// Directed polls cover wrap, bounce and the limit edges, then randomized
// press runs and noise cover several limit settings with random stalls.
// ---------------------------------------------------------------------------
module tb_button_debounce_press_classifier_top;
	import bdpc_pkg::*;

	// tracks the press machine and holds the flag words still to come
	class press_tracker;
		press_state_t state;
		time_t entry_stamp;
		limit_t debounce_ms;
		limit_t long_ms;
		result_t expected_flags[$];
		int errors;

		function new();
			state = ST_IDLE;
			entry_stamp = '0;
			debounce_ms = DebounceReset;
			long_ms = LongPressReset;
			errors = 0;
		endfunction

		function void set_limit(logic index, limit_t value);
			if (index == RegDebounce) debounce_ms = value;
			else long_ms = value;
		endfunction

		function void note_poll(logic level, time_t now);
			result_t flags;
			time_t elapsed;
			flags = '0;
			elapsed = now - entry_stamp;
			case (state)
				ST_IDLE: begin
					if (level) begin
						state = ST_DEB_PRESS;
						entry_stamp = now;
					end
				end
				ST_DEB_PRESS: begin
					if (!level) begin
						state = ST_IDLE;
					end else if (elapsed >= debounce_ms) begin
						state = ST_PRESSED;
						entry_stamp = now;
					end
				end
				ST_PRESSED: begin
					if (!level) begin
						if (elapsed >= long_ms) flags.long_press = 1'b1;
						else flags.short_press = 1'b1;
						state = ST_DEB_RELEASE;
						entry_stamp = now;
					end
				end
				default: begin
					// level ignored here, only time counts
					if (elapsed >= debounce_ms) state = ST_IDLE;
				end
			endcase
			flags.held = (state == ST_PRESSED);
			expected_flags.push_back(flags);
		endfunction

		function void check_flags(result_t got);
			result_t want;
			if (expected_flags.size() == 0) begin
				$error("result word with no poll pending: %b", got);
				errors++;
				return;
			end
			want = expected_flags.pop_front();
			if (got.short_press !== want.short_press) begin
				$error("short_press: expected %0b, got %0b", want.short_press, got.short_press);
				errors++;
			end
			if (got.long_press !== want.long_press) begin
				$error("long_press: expected %0b, got %0b", want.long_press, got.long_press);
				errors++;
			end
			if (got.held !== want.held) begin
				$error("held: expected %0b, got %0b", want.held, got.held);
				errors++;
			end
		endfunction

		function int pending();
			return expected_flags.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [InDataBits-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OutDataBits-1:0] m_axis_tdata;
	logic cfg_we;
	logic cfg_index;
	limit_t cfg_data;

	press_tracker tracker = new();
	bit steady;
	bit ready_on;
	int unsigned ready_left;
	time_t tick;
	limit_t cur_debounce;
	limit_t cur_long;
	int polls_sent;

	button_debounce_press_classifier_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	always @(negedge clk) begin
		if (steady) begin
			m_axis_tready <= 1'b1;
		end else begin
			if (ready_left == 0) begin
				ready_on = ($urandom_range(0, 3) != 0);
				ready_left = ready_on ? $urandom_range(1, 24) : pick_gap() + 1;
			end
			m_axis_tready <= ready_on;
			ready_left--;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) tracker.check_flags(m_axis_tdata[2:0]);
	end

	// all driving tasks start and end at a falling edge
	task automatic send_poll(logic level, time_t now);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(InDataBits-33){1'b0}}, now, level};
		do @(posedge clk); while (!s_axis_tready);
		tracker.note_poll(level, now);
		polls_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_limit(logic index, limit_t value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.set_limit(index, value);
		if (index == RegDebounce) cur_debounce = value;
		else cur_long = value;
		@(negedge clk);
	endtask

	// one press with optional bounce, debounce-window polls and release polls
	task automatic press_run();
		time_t t_start;
		time_t t_acc;
		time_t t_rel;
		int unsigned hold;
		repeat ($urandom_range(0, 2)) begin
			tick += $urandom_range(0, 50);
			send_poll(1'b0, tick);
		end
		repeat ($urandom_range(0, 2)) begin
			send_poll(1'b1, tick);
			tick += $urandom_range(0, cur_debounce);
			send_poll(1'b0, tick);
			tick += 1;
		end
		t_start = tick;
		send_poll(1'b1, t_start);
		repeat ($urandom_range(0, 2))
			if (cur_debounce > 0) send_poll(1'b1, t_start + $urandom_range(0, cur_debounce - 1));
		t_acc = t_start + cur_debounce + $urandom_range(0, 2);
		send_poll(1'b1, t_acc);
		case ($urandom_range(0, 3))
			0: hold = (cur_long == 0) ? 0 : cur_long - 1;
			1: hold = cur_long;
			2: hold = $urandom_range(0, cur_long);
			default: hold = cur_long + $urandom_range(1, 3000);
		endcase
		repeat ($urandom_range(0, 4)) send_poll(1'b1, t_acc + $urandom_range(0, hold));
		t_rel = t_acc + hold;
		send_poll(1'b0, t_rel);
		repeat ($urandom_range(0, 3))
			if (cur_debounce > 0)
				send_poll(1'($urandom_range(0, 1)), t_rel + $urandom_range(0, cur_debounce - 1));
		tick = t_rel + cur_debounce + $urandom_range(0, 3);
		send_poll(1'b0, tick);
	endtask

	task automatic random_phase(limit_t deb, limit_t lng, int count);
		int stop_at;
		drain();
		write_limit(RegDebounce, deb);
		write_limit(RegLongPress, lng);
		tick = ($urandom_range(0, 3) == 0) ? 32'hFFFF_0000 + $urandom_range(0, 16'hFFFF)
			: $urandom();
		stop_at = polls_sent + count;
		while (polls_sent < stop_at) begin
			steady = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 4)) send_poll(1'($urandom_range(0, 1)), $urandom());
			end else begin
				press_run();
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = RegDebounce;
		cfg_data = '0;
		steady = 1'b0;
		ready_on = 1'b0;
		ready_left = 0;
		polls_sent = 0;
		cur_debounce = DebounceReset;
		cur_long = LongPressReset;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset limits, press debounce across the time wrap
		send_poll(1'b0, 32'h0000_0000);
		send_poll(1'b1, 32'hFFFF_FFF0);
		send_poll(1'b1, 32'h0000_0021);
		send_poll(1'b1, 32'h0000_0022);
		send_poll(1'b1, 32'hFFFF_FFFF);
		send_poll(1'b0, 32'h0000_0022 + 999);
		send_poll(1'b1, 32'h0000_0022 + 999 + 49);
		send_poll(1'b1, 32'h0000_0022 + 999 + 50);
		// bounce back to idle, then a long press exactly at the limit
		send_poll(1'b0, 32'h0000_0500);
		send_poll(1'b1, 32'h0000_0510);
		send_poll(1'b0, 32'h0000_0520);
		send_poll(1'b1, 32'h0000_0600);
		send_poll(1'b1, 32'h0000_0632);
		send_poll(1'b0, 32'h0000_0632 + 1000);
		send_poll(1'b0, 32'h0000_0632 + 1050);
		// zero limits: accept at once, every release is long
		drain();
		write_limit(RegDebounce, 16'd0);
		write_limit(RegLongPress, 16'd0);
		send_poll(1'b1, 32'd100);
		send_poll(1'b1, 32'd100);
		send_poll(1'b0, 32'd100);
		send_poll(1'b0, 32'd100);

		random_phase(DebounceReset, LongPressReset, 125);
		random_phase(16'd0, 16'd0, 125);
		random_phase(16'hFFFF, 16'hFFFF, 125);
		random_phase(16'd5, 16'd40, 125);
		// hold off until the pipeline is empty mid-setting
		drain();
		random_phase(16'd0, 16'd100, 125);
		random_phase(16'd30, 16'd0, 125);
		random_phase(16'($urandom_range(0, 200)), 16'($urandom_range(0, 2000)), 125);
		random_phase(16'hFFFF, 16'd0, 60);
		random_phase(16'd1, 16'hFFFF, 60);

		drain();
		repeat (8) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("tb_button_debounce_press_classifier_top passed");
		end else begin
			$display("tb_button_debounce_press_classifier_top failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_button_debounce_press_classifier_top failed");
		$finish;
	end

endmodule
